// ----- rtl/core/gts_pkg.sv -----
package gts_pkg;

    // Nanoseconds in one second, fits in 30 bits.
    localparam int NS_W = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    // The period word keeps only its low 31 bits.
    localparam int PERIOD_W = 31;

    // Product of the clock count and one second in nanoseconds.
    localparam int PROD_W = 32 + NS_W;

    // Divider layout: two quotient bits resolved in each stage.
    localparam int QUO_W = 32;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STAGES = QUO_W / DIV_RADIX_BITS;

    // Calendar constants. The March-based year is biased by one full
    // 400-year era so that every floor division works on a positive value.
    localparam int YEAR_W = 13;
    localparam logic [YEAR_W-1:0] YEAR_BIAS = 13'd400;
    localparam logic [31:0] DAYS_BIAS = 32'd865565;
    localparam logic [31:0] SEC_PER_DAY = 32'd86400;

    // Division by 25 as a multiply by a reciprocal; exact below 43690.
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam int RECIP_SHIFT = 17;

    // Day offset of the first of each month in a year that starts in March.
    function automatic logic [8:0] month_offset(input logic [7:0] month);
        logic [8:0] offset;
        case (month)
            8'd3:    offset = 9'd0;
            8'd4:    offset = 9'd31;
            8'd5:    offset = 9'd61;
            8'd6:    offset = 9'd92;
            8'd7:    offset = 9'd122;
            8'd8:    offset = 9'd153;
            8'd9:    offset = 9'd184;
            8'd10:   offset = 9'd214;
            8'd11:   offset = 9'd245;
            8'd12:   offset = 9'd275;
            8'd1:    offset = 9'd306;
            8'd2:    offset = 9'd337;
            default: offset = 9'd0;
        endcase
        return offset;
    endfunction

    // Word handed from the front end to the divider.
    typedef struct packed {
        logic [PROD_W-1:0]   prod;
        logic [PERIOD_W-1:0] period;
        logic [31:0]         secs;
        logic                date_err;
        logic                period_zero;
        logic                sat;
    } gts_front_out_t;

    // Word handed from the divider to the output stages.
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [31:0]      secs;
        logic             date_err;
        logic             period_zero;
        logic             sat;
    } gts_div_out_t;

endpackage

// ----- rtl/core/gts_front.sv -----
module gts_front import gts_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [11:0]    year,
    input  logic [7:0]     month,
    input  logic [7:0]     day,
    input  logic [7:0]     hour,
    input  logic [7:0]     minute,
    input  logic [7:0]     second,
    input  logic [7:0]     leap_seconds,
    input  logic [31:0]    clock_count,
    input  logic [31:0]    clock_period,
    output logic           out_valid,
    input  logic           out_ready,
    output gts_front_out_t out_word
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] rdy;

    // Stage 1 registers.
    logic [YEAR_W-1:0]   y1_reg;
    logic [8:0]          doy1_reg;
    logic [17:0]         hms1_reg;
    logic                err1_reg;
    logic [PROD_W-1:0]   prod1_reg;
    logic [PERIOD_W-1:0] per1_reg;

    // Stage 2 registers.
    logic [20:0]         y365_2_reg;
    logic [10:0]         y4_2_reg;
    logic [5:0]          c100_2_reg;
    logic [3:0]          c400_2_reg;
    logic [8:0]          doy2_reg;
    logic [17:0]         hms2_reg;
    logic                err2_reg;
    logic [PROD_W-1:0]   prod2_reg;
    logic [PERIOD_W-1:0] per2_reg;
    logic                pz2_reg;
    logic                sat2_reg;

    // Stage 3 registers.
    logic [31:0]         days3_reg;
    logic [17:0]         hms3_reg;
    logic                err3_reg;
    logic [PROD_W-1:0]   prod3_reg;
    logic [PERIOD_W-1:0] per3_reg;
    logic                pz3_reg;
    logic                sat3_reg;

    // Stage 4 register.
    gts_front_out_t      out_reg;

    // Combinational values feeding the stages.
    logic                early_next;
    logic [YEAR_W-1:0]   y1_next;
    logic [8:0]          doy1_next;
    logic [17:0]         hms1_next;
    logic                err1_next;
    logic [PROD_W-1:0]   prod1_next;
    logic [22:0]         c100_full;
    logic [20:0]         c400_full;
    logic [31:0]         days3_next;
    logic [31:0]         secs4_next;

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
    for (genvar i = 0; i < NSTG - 1; i++) begin : g_rdy
        assign rdy[i] = !valid_reg[i] || rdy[i+1];
    end
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_word  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: range check, March-based year, day of year, time of day and
    // the count scaled to nanoseconds.
    always_comb begin
        err1_next = !(month inside {[8'd1:8'd12]}) || !(day inside {[8'd1:8'd31]}) ||
                    (hour > 8'd23) || (minute > 8'd59) || (second > 8'd60);
        early_next = (month <= 8'd2);
        y1_next = {1'b0, year} + YEAR_BIAS - {{(YEAR_W-1){1'b0}}, early_next};
        doy1_next = month_offset(month) + {1'b0, day} - 9'd1;
        hms1_next = 18'(hour) * 18'd3600 + 18'(minute) * 18'd60 + 18'(second)
                    - 18'(leap_seconds);
        prod1_next = {{NS_W{1'b0}}, clock_count} * {{32{1'b0}}, NS_PER_SEC};
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            y1_reg    <= y1_next;
            doy1_reg  <= doy1_next;
            hms1_reg  <= hms1_next;
            err1_reg  <= err1_next;
            prod1_reg <= prod1_next;
            per1_reg  <= clock_period[PERIOD_W-1:0];
        end
    end

    // Stage 2: century and era counts, and the saturation test. The
    // quotient overflows 32 bits exactly when the upper product word
    // reaches the period.
    always_comb begin
        c100_full = 23'(y1_reg[YEAR_W-1:2]) * 23'(RECIP25);
        c400_full = 21'(y1_reg[YEAR_W-1:4]) * 21'(RECIP25);
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            y365_2_reg <= 21'(y1_reg) * 21'd365;
            y4_2_reg   <= y1_reg[YEAR_W-1:2];
            c100_2_reg <= c100_full[RECIP_SHIFT+5:RECIP_SHIFT];
            c400_2_reg <= c400_full[RECIP_SHIFT+3:RECIP_SHIFT];
            doy2_reg   <= doy1_reg;
            hms2_reg   <= hms1_reg;
            err2_reg   <= err1_reg;
            prod2_reg  <= prod1_reg;
            per2_reg   <= per1_reg;
            pz2_reg    <= (per1_reg == '0);
            sat2_reg   <= ({1'b0, prod1_reg[PROD_W-1:32]} >= per1_reg);
        end
    end

    // Stage 3: days since 1970, modulo 2^32.
    always_comb begin
        days3_next = 32'(y365_2_reg) + 32'(y4_2_reg) - 32'(c100_2_reg)
                     + 32'(c400_2_reg) + 32'(doy2_reg) - DAYS_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            days3_reg <= days3_next;
            hms3_reg  <= hms2_reg;
            err3_reg  <= err2_reg;
            prod3_reg <= prod2_reg;
            per3_reg  <= per2_reg;
            pz3_reg   <= pz2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // Stage 4: seconds since 1970; a bad date gives zero.
    always_comb begin
        secs4_next = days3_reg * SEC_PER_DAY + {{14{hms3_reg[17]}}, hms3_reg};
        if (err3_reg) begin
            secs4_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            out_reg.prod        <= prod3_reg;
            out_reg.period      <= per3_reg;
            out_reg.secs        <= secs4_next;
            out_reg.date_err    <= err3_reg;
            out_reg.period_zero <= pz3_reg;
            out_reg.sat         <= sat3_reg;
        end
    end

endmodule

// ----- rtl/core/gts_divider.sv -----
module gts_divider import gts_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gts_front_out_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output gts_div_out_t   out_word
);

    // Partial division state carried from stage to stage.
    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [31:0]         low;
        logic [QUO_W-1:0]    quo;
        logic [PERIOD_W-1:0] period;
        logic [31:0]         secs;
        logic                date_err;
        logic                period_zero;
        logic                sat;
    } gts_div_stage_t;

    // Restoring division steps; the remainder stays below the period when the word is not saturated.
    function automatic gts_div_stage_t div_step(input gts_div_stage_t s);
        logic [PERIOD_W:0] trial;
        logic [PERIOD_W:0] pext;
        gts_div_stage_t    r;
        r = s;
        pext = {1'b0, s.period};
        for (int b = 0; b < DIV_RADIX_BITS; b++) begin
            trial = {r.rem, r.low[31]};
            r.low = {r.low[30:0], 1'b0};
            if (trial >= pext) begin
                trial = trial - pext;
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end else begin
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
            r.rem = trial[PERIOD_W-1:0];
        end
        return r;
    endfunction

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] rdy;
    gts_div_stage_t        stage_reg [DIV_STAGES];
    gts_div_stage_t        init_word;

    // The upper product word is the first partial remainder.
    always_comb begin
        init_word.rem         = {1'b0, in_word.prod[PROD_W-1:32]};
        init_word.low         = in_word.prod[31:0];
        init_word.quo         = '0;
        init_word.period      = in_word.period;
        init_word.secs        = in_word.secs;
        init_word.date_err    = in_word.date_err;
        init_word.period_zero = in_word.period_zero;
        init_word.sat         = in_word.sat;
    end

    assign rdy[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || out_ready;
    assign in_ready = rdy[0];
    assign out_valid = valid_reg[DIV_STAGES-1];

    // One register stage per pair of quotient bits.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        gts_div_stage_t cur;
        if (k == 0) begin : g_first
            assign cur = init_word;
        end else begin : g_rest
            assign cur = stage_reg[k-1];
            assign rdy[k-1] = !valid_reg[k-1] || rdy[k];
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                stage_reg[k] <= div_step(cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < DIV_STAGES; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Hand the quotient and the carried fields on.
    always_comb begin
        out_word.quo         = stage_reg[DIV_STAGES-1].quo;
        out_word.secs        = stage_reg[DIV_STAGES-1].secs;
        out_word.date_err    = stage_reg[DIV_STAGES-1].date_err;
        out_word.period_zero = stage_reg[DIV_STAGES-1].period_zero;
        out_word.sat         = stage_reg[DIV_STAGES-1].sat;
    end

endmodule

// ----- rtl/core/gts_back.sv -----
module gts_back import gts_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  gts_div_out_t in_word,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  epoch_seconds,
    output logic [31:0]  nanoseconds,
    output logic [63:0]  total_nanoseconds,
    output logic         date_error,
    output logic         fraction_saturated
);

    logic [1:0]  valid_reg;
    logic [1:0]  rdy;

    logic [31:0] secs1_reg;
    logic [31:0] ns1_reg;
    logic [63:0] sec_ns1_reg;
    logic        err1_reg;
    logic        sat1_reg;

    logic [31:0] secs2_reg;
    logic [31:0] ns2_reg;
    logic [63:0] total2_reg;
    logic        err2_reg;
    logic        sat2_reg;

    logic [31:0] ns_next;
    logic        sat_next;

    assign rdy[1]    = !valid_reg[1] || out_ready;
    assign rdy[0]    = !valid_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    // A zero period gives no fraction; an overflowing one pins to all ones.
    always_comb begin
        ns_next  = in_word.quo;
        sat_next = in_word.sat;
        if (in_word.period_zero) begin
            ns_next  = '0;
            sat_next = 1'b0;
        end else if (in_word.sat) begin
            ns_next = '1;
        end
    end

    // First stage: whole seconds scaled to nanoseconds.
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            secs1_reg   <= in_word.secs;
            ns1_reg     <= ns_next;
            sec_ns1_reg <= {32'd0, in_word.secs} * {34'd0, NS_PER_SEC};
            err1_reg    <= in_word.date_err;
            sat1_reg    <= sat_next;
        end
    end

    // Second stage: add the fraction and hold the result word.
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            secs2_reg  <= secs1_reg;
            ns2_reg    <= ns1_reg;
            total2_reg <= sec_ns1_reg + {32'd0, ns1_reg};
            err2_reg   <= err1_reg;
            sat2_reg   <= sat1_reg;
        end
    end

    assign epoch_seconds      = secs2_reg;
    assign nanoseconds        = ns2_reg;
    assign total_nanoseconds  = total2_reg;
    assign date_error         = err2_reg;
    assign fraction_saturated = sat2_reg;

endmodule

// ----- rtl/core/gps_event_timestamp.sv -----
// GPS event time stamper. Each word carries one event's GPS date and time,
// the leap-second count, the clock count since the last pulse per second and
// the clock count per second (bit 31 ignored). The result word gives UTC
// seconds since 1970 (modulo 2^32), the fraction of the second in whole
// nanoseconds, and the total in nanoseconds. One word is taken every cycle
// while the output is not stalled; each word passes four front-end stages
// for the calendar and the count scaling, sixteen divider stages that each
// resolve two quotient bits, and two stages for the total. Every stage holds
// its word under back pressure, so bubbles are squeezed out and nothing is
// lost. A bad calendar field sets date_error and gives zero seconds; a zero
// period gives zero nanoseconds; a fraction past 32 bits is pinned to all
// ones with fraction_saturated set.
module gps_event_timestamp import gts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_year,
    input  logic [7:0]  s_month,
    input  logic [7:0]  s_day,
    input  logic [7:0]  s_hour,
    input  logic [7:0]  s_minute,
    input  logic [7:0]  s_second,
    input  logic [7:0]  s_leap_seconds,
    input  logic [31:0] s_clock_count,
    input  logic [31:0] s_clock_period,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_epoch_seconds,
    output logic [31:0] m_nanoseconds,
    output logic [63:0] m_total_nanoseconds,
    output logic        m_date_error,
    output logic        m_fraction_saturated
);

    gts_front_out_t front_word;
    logic           front_valid;
    logic           front_ready;
    gts_div_out_t   div_word;
    logic           div_valid;
    logic           div_ready;

    // Calendar and count scaling.
    gts_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .year         (s_year),
        .month        (s_month),
        .day          (s_day),
        .hour         (s_hour),
        .minute       (s_minute),
        .second       (s_second),
        .leap_seconds (s_leap_seconds),
        .clock_count  (s_clock_count),
        .clock_period (s_clock_period),
        .out_valid    (front_valid),
        .out_ready    (front_ready),
        .out_word     (front_word)
    );

    // Fraction of the second.
    gts_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_word   (front_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    // Fraction clean-up, total and result register.
    gts_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (div_valid),
        .in_ready           (div_ready),
        .in_word            (div_word),
        .out_valid          (m_valid),
        .out_ready          (m_ready),
        .epoch_seconds      (m_epoch_seconds),
        .nanoseconds        (m_nanoseconds),
        .total_nanoseconds  (m_total_nanoseconds),
        .date_error         (m_date_error),
        .fraction_saturated (m_fraction_saturated)
    );

endmodule

// ----- tb/gps_event_timestamp_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the time stamper. Every event word accepted on
// the input side is turned into the stamp it should produce, and every result
// word is compared field by field with the oldest stamp still due.
module gps_event_timestamp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [11:0] s_year,
    input  logic [7:0]  s_month,
    input  logic [7:0]  s_day,
    input  logic [7:0]  s_hour,
    input  logic [7:0]  s_minute,
    input  logic [7:0]  s_second,
    input  logic [7:0]  s_leap_seconds,
    input  logic [31:0] s_clock_count,
    input  logic [31:0] s_clock_period,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_epoch_seconds,
    input  logic [31:0] m_nanoseconds,
    input  logic [63:0] m_total_nanoseconds,
    input  logic        m_date_error,
    input  logic        m_fraction_saturated,
    output int          mismatches,
    output int          stamps_pending
);

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [31:0] nanoseconds;
        logic [63:0] total_nanoseconds;
        logic        date_error;
        logic        fraction_saturated;
    } stamp_t;

    localparam logic [63:0] ONE_SECOND_NS = 64'd1000000000;

    // Ring of stamps still due; far deeper than the pipeline.
    localparam int DUE_DEPTH = 64;

    stamp_t     stamps_due [DUE_DEPTH];
    logic [5:0] due_head;
    logic [5:0] due_tail;
    int         due_count;
    stamp_t     want;

    initial begin
        mismatches = 0;
        stamps_pending = 0;
        due_head = '0;
        due_tail = '0;
        due_count = 0;
    end

    // Works out the stamp of one event: days from the civil date (March-based
    // year, 400-year eras), minus the leap seconds, plus the scaled fraction.
    function automatic stamp_t predict_stamp(
        input logic [11:0] year,
        input logic [7:0]  month,
        input logic [7:0]  day,
        input logic [7:0]  hour,
        input logic [7:0]  minute,
        input logic [7:0]  second,
        input logic [7:0]  leap,
        input logic [31:0] count,
        input logic [31:0] period_word
    );
        longint y;
        longint m;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        longint days;
        longint secs;
        logic [30:0] period;
        logic [63:0] quotient;
        stamp_t s;

        s = '0;
        s.date_error = (month < 8'd1) || (month > 8'd12) || (day < 8'd1) ||
                       (day > 8'd31) || (hour > 8'd23) || (minute > 8'd59) ||
                       (second > 8'd60);

        // Calendar part; a bad field leaves the seconds at zero.
        if (!s.date_error) begin
            y = longint'(year);
            m = longint'(month);
            if (m <= 2) begin
                y = y - 1;
            end
            era = ((y >= 0) ? y : y - 399) / 400;
            yoe = y - era * 400;
            doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + longint'(day) - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            secs = days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
                 + longint'(second) - longint'(leap);
            s.epoch_seconds = 32'(secs);
        end

        // Fraction of the second; bit 31 of the period is ignored, and a
        // zero period gives zero nanoseconds.
        period = period_word[30:0];
        if (period != '0) begin
            quotient = ({32'd0, count} * ONE_SECOND_NS) / {33'd0, period};
            if (quotient > 64'hFFFF_FFFF) begin
                s.nanoseconds = '1;
                s.fraction_saturated = 1'b1;
            end else begin
                s.nanoseconds = quotient[31:0];
            end
        end

        s.total_nanoseconds = {32'd0, s.epoch_seconds} * ONE_SECOND_NS
                            + {32'd0, s.nanoseconds};
        return s;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (mismatches < 10) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $realtime, name, exp_v, act_v);
            end
            mismatches++;
        end
    endtask

    // Results are taken before new events so that a word can never be
    // matched against a stamp queued at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_count == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result word with no event pending, seconds %0h",
                                 $realtime, m_epoch_seconds);
                    end
                    mismatches++;
                end else begin
                    want = stamps_due[due_head];
                    due_head = due_head + 6'd1;
                    due_count--;
                    compare_field("epoch_seconds", 64'(want.epoch_seconds),
                                  64'(m_epoch_seconds));
                    compare_field("nanoseconds", 64'(want.nanoseconds),
                                  64'(m_nanoseconds));
                    compare_field("total_nanoseconds", want.total_nanoseconds,
                                  m_total_nanoseconds);
                    compare_field("date_error", 64'(want.date_error),
                                  64'(m_date_error));
                    compare_field("fraction_saturated", 64'(want.fraction_saturated),
                                  64'(m_fraction_saturated));
                end
            end
            if (s_valid && s_ready) begin
                if (due_count == DUE_DEPTH) begin
                    if (mismatches < 10) begin
                        $display("%0t: more event words in flight than the pipeline holds",
                                 $realtime);
                    end
                    mismatches++;
                end else begin
                    stamps_due[due_tail] = predict_stamp(s_year, s_month, s_day, s_hour,
                                                         s_minute, s_second,
                                                         s_leap_seconds, s_clock_count,
                                                         s_clock_period);
                    due_tail = due_tail + 6'd1;
                    due_count++;
                end
            end
        end
        stamps_pending <= due_count;
    end

endmodule

// ----- tb/tb_gps_event_timestamp.sv -----
`timescale 1ns / 1ps

module tb_gps_event_timestamp;

    typedef struct packed {
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  leap_seconds;
        logic [31:0] clock_count;
        logic [31:0] clock_period;
    } gps_event_t;

    localparam int EVENTS_PER_PHASE = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_year = '0;
    logic [7:0]  s_month = '0;
    logic [7:0]  s_day = '0;
    logic [7:0]  s_hour = '0;
    logic [7:0]  s_minute = '0;
    logic [7:0]  s_second = '0;
    logic [7:0]  s_leap_seconds = '0;
    logic [31:0] s_clock_count = '0;
    logic [31:0] s_clock_period = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_epoch_seconds;
    logic [31:0] m_nanoseconds;
    logic [63:0] m_total_nanoseconds;
    logic        m_date_error;
    logic        m_fraction_saturated;

    int mismatches;
    int stamps_pending;
    int send_idle_pct = 13;
    int recv_idle_pct = 83;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gps_event_timestamp DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_year               (s_year),
        .s_month              (s_month),
        .s_day                (s_day),
        .s_hour               (s_hour),
        .s_minute             (s_minute),
        .s_second             (s_second),
        .s_leap_seconds       (s_leap_seconds),
        .s_clock_count        (s_clock_count),
        .s_clock_period       (s_clock_period),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_epoch_seconds      (m_epoch_seconds),
        .m_nanoseconds        (m_nanoseconds),
        .m_total_nanoseconds  (m_total_nanoseconds),
        .m_date_error         (m_date_error),
        .m_fraction_saturated (m_fraction_saturated)
    );

    gps_event_timestamp_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_year               (s_year),
        .s_month              (s_month),
        .s_day                (s_day),
        .s_hour               (s_hour),
        .s_minute             (s_minute),
        .s_second             (s_second),
        .s_leap_seconds       (s_leap_seconds),
        .s_clock_count        (s_clock_count),
        .s_clock_period       (s_clock_period),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_epoch_seconds      (m_epoch_seconds),
        .m_nanoseconds        (m_nanoseconds),
        .m_total_nanoseconds  (m_total_nanoseconds),
        .m_date_error         (m_date_error),
        .m_fraction_saturated (m_fraction_saturated),
        .mismatches           (mismatches),
        .stamps_pending       (stamps_pending)
    );

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic gps_event_t make_event(
        input int year, input int month, input int day, input int hour,
        input int minute, input int second, input int leap,
        input logic [31:0] count, input logic [31:0] period
    );
        gps_event_t e;
        e.year = 12'(year);
        e.month = 8'(month);
        e.day = 8'(day);
        e.hour = 8'(hour);
        e.minute = 8'(minute);
        e.second = 8'(second);
        e.leap_seconds = 8'(leap);
        e.clock_count = count;
        e.clock_period = period;
        return e;
    endfunction

    // Presents one event word, after idle cycles at the rate of the current
    // phase, and holds it until the block takes it.
    task automatic send_event(input gps_event_t e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_year <= e.year;
        s_month <= e.month;
        s_day <= e.day;
        s_hour <= e.hour;
        s_minute <= e.minute;
        s_second <= e.second;
        s_leap_seconds <= e.leap_seconds;
        s_clock_count <= e.clock_count;
        s_clock_period <= e.clock_period;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending and waits until every stamp due has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (stamps_pending != 0);
    endtask

    initial begin
        gps_event_t e;
        int kind;
        logic [30:0] period_low;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: field extremes, every bad calendar field, zero
        // period, saturation, day past month end and leap borrow.
        send_event(make_event(1970, 1, 1, 0, 0, 0, 0, 32'd0, 32'd1));
        send_event(make_event(2105, 12, 31, 23, 59, 60, 0, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        send_event(make_event(0, 1, 1, 0, 0, 0, 0, 32'd12345, 32'd100_000_000));
        send_event(make_event(4095, 12, 31, 23, 59, 59, 255, 32'd99_999_999,
                              32'd100_000_000));
        send_event(make_event(2024, 0, 15, 10, 30, 30, 18, 32'd500, 32'd1000));
        send_event(make_event(2024, 13, 15, 10, 30, 30, 18, 32'd1, 32'd3));
        send_event(make_event(2024, 255, 15, 10, 30, 30, 18, 32'd7, 32'd9));
        send_event(make_event(2024, 6, 0, 10, 30, 30, 18, 32'd2, 32'd3));
        send_event(make_event(2024, 6, 32, 10, 30, 30, 18, 32'd8, 32'd9));
        send_event(make_event(2024, 6, 255, 10, 30, 30, 18, 32'd10, 32'd3));
        send_event(make_event(2024, 6, 15, 24, 30, 30, 18, 32'd1, 32'd2));
        send_event(make_event(2024, 6, 15, 255, 30, 30, 18, 32'd0, 32'd2));
        send_event(make_event(2024, 6, 15, 10, 60, 30, 18, 32'd33, 32'd100));
        send_event(make_event(2024, 6, 15, 10, 255, 30, 18, 32'd66, 32'd100));
        send_event(make_event(2024, 6, 15, 10, 30, 61, 18, 32'd99, 32'd100));
        send_event(make_event(2024, 6, 15, 10, 30, 255, 18, 32'd1, 32'd100));
        send_event(make_event(2020, 6, 1, 12, 0, 0, 18, 32'd5000, 32'd0));
        send_event(make_event(2020, 6, 1, 12, 0, 0, 18, 32'hFFFF_FFFF, 32'h8000_0000));
        send_event(make_event(2030, 3, 1, 0, 0, 0, 0, 32'd5, 32'd1));
        send_event(make_event(2030, 3, 1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'd1));
        send_event(make_event(2030, 3, 1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_event(make_event(2023, 2, 31, 8, 15, 45, 18, 32'd1, 32'd1));
        send_event(make_event(2100, 2, 29, 8, 15, 45, 18, 32'd3, 32'd7));
        send_event(make_event(1970, 1, 1, 0, 0, 0, 255, 32'd0, 32'd50_000_000));

        // Hold off until the pipeline is empty before the random traffic.
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 83;
                recv_idle_pct = 13;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                kind = $urandom_range(99);
                e.year = (kind < 85) ? 12'($urandom_range(1970, 2105)) : 12'($urandom);

                // Mostly sane calendar fields, the rest raw bytes.
                if (kind < 80) begin
                    e.month = 8'($urandom_range(1, 12));
                    e.day = 8'($urandom_range(1, 31));
                    e.hour = 8'($urandom_range(0, 23));
                    e.minute = 8'($urandom_range(0, 59));
                    e.second = 8'($urandom_range(0, 60));
                end else begin
                    e.month = 8'($urandom);
                    e.day = 8'($urandom);
                    e.hour = 8'($urandom);
                    e.minute = 8'($urandom);
                    e.second = 8'($urandom);
                end
                e.leap_seconds = ($urandom_range(3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 37));

                // Periods from realistic oscillator rates to tiny and huge.
                case ($urandom_range(3))
                    0: e.clock_period = $urandom_range(10_000_000, 250_000_000);
                    1: e.clock_period = $urandom;
                    2: e.clock_period = $urandom_range(1, 1000);
                    default: e.clock_period = $urandom_range(1, 32'h7FFF_FFFF);
                endcase
                if ($urandom_range(49) == 0) begin
                    e.clock_period[30:0] = '0;
                end
                e.clock_period[31] = 1'($urandom_range(1));

                // The count usually stays below the period, as real pulses do.
                period_low = e.clock_period[30:0];
                if (period_low != '0 && $urandom_range(9) < 8) begin
                    e.clock_count = $urandom_range(0, 32'(period_low) - 1);
                end else begin
                    e.clock_count = $urandom;
                end
                send_event(e);
            end
            wait_drained();
        end

        // Give any stray word time to show up after the last stamp.
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[gps_event_timestamp] OK");
        end else begin
            $display("[gps_event_timestamp] ERROR");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("[gps_event_timestamp] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gts_pkg.sv
rtl/core/gts_front.sv
rtl/core/gts_divider.sv
rtl/core/gts_back.sv
rtl/core/gps_event_timestamp.sv
tb/gps_event_timestamp_checker.sv
tb/tb_gps_event_timestamp.sv
